// ----- src/dsproj_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsproj_pkg;

  // field and coefficient widths
  localparam int unsigned DirW    = 16;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned RowW    = 3 * CoefW;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned OutW    = 16;
  localparam int unsigned CfgIdxW = 3;

  // internal datapath widths (all exact, no rounding before the divide)
  localparam int unsigned Prod1W  = DirW + CoefW;        // coef * dir
  localparam int unsigned EyeW    = Prod1W + 1;          // sum of three, q.26
  localparam int unsigned Prod2W  = 48;                  // coef * eye, bounded by 3*2^45
  localparam int unsigned ClipW   = 50;                  // sum of three, q.38
  localparam int unsigned SumW    = ClipW + 1;           // cx + cw, cw - cy
  localparam int unsigned SplitLo = 26;                  // low slice of the scale multiply
  localparam int unsigned SplitHi = SumW - SplitLo;
  localparam int unsigned ScaleW  = SplitLo + SizeW;     // partial product width
  localparam int unsigned NumW    = 64;                  // rounded numerator
  localparam int unsigned RemW    = NumW - 1;            // magnitude after folding the sign
  localparam int unsigned DenW    = ClipW;               // 2 * cw, positive when visible
  localparam int unsigned DivSteps = OutW;               // one quotient bit per stage
  localparam int unsigned DivW    = RemW + 3;            // room for den << (DivSteps-1) and sign

  // clip w at or above this (q.38) means in front of the camera
  localparam logic signed [ClipW-1:0] CwThreshold = 50'sd274877907;

  // reset values
  localparam logic [RowW-1:0] UnitRow [3] = '{48'h0000_0000_1000,
                                             48'h0000_1000_0000,
                                             48'h1000_0000_0000};
  localparam logic [SizeW-1:0] WidthReset  = 13'd1920;
  localparam logic [SizeW-1:0] HeightReset = 13'd1080;

  // register map
  typedef enum logic [CfgIdxW-1:0] {
    RegViewRowX  = 3'd0,
    RegViewRowY  = 3'd1,
    RegViewRowZ  = 3'd2,
    RegProjRowX  = 3'd3,
    RegProjRowY  = 3'd4,
    RegProjRowW  = 3'd5,
    RegScreenW   = 3'd6,
    RegScreenH   = 3'd7
  } cfg_reg_e;

  // signed coefficient k of a packed row
  function automatic logic signed [CoefW-1:0] coef(logic [RowW-1:0] row, int unsigned k);
    return $signed(row[CoefW*k +: CoefW]);
  endfunction

endpackage

`default_nettype wire

// ----- src/direction_screen_projection_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------
// input     | in_valid_i / in_ready_o | dir_x_i, dir_y_i, dir_z_i
// result    | out_valid_o / out_ready_i | visible_o, screen_x_o, screen_y_o
// config    | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one request per cycle while the result is not held; a request passes seven
// arithmetic stages, the 16-stage restoring quotient pipeline (one quotient
// bit per stage) and then the output register.
// reset clears the stage valid bits and loads the identity matrices and
// a 1920 x 1080 viewport. a held result freezes every stage in place, so
// nothing is dropped or repeated; the input side stalls with it.

module direction_screen_projection_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input channel
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic signed [dsproj_pkg::DirW-1:0] dir_x_i,
  input  wire logic signed [dsproj_pkg::DirW-1:0] dir_y_i,
  input  wire logic signed [dsproj_pkg::DirW-1:0] dir_z_i,
  // result channel
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      logic                               visible_o,
  output      logic signed [dsproj_pkg::OutW-1:0] screen_x_o,
  output      logic signed [dsproj_pkg::OutW-1:0] screen_y_o,
  // configuration write channel
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [dsproj_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [dsproj_pkg::RowW-1:0]        cfg_data_i
);

  localparam int unsigned FrontStages = 7;
  localparam int unsigned NumStages   = FrontStages + dsproj_pkg::DivSteps + 1;
  localparam int unsigned LastStage   = NumStages - 1;

  // configuration registers
  logic [dsproj_pkg::RowW-1:0]  view_row_q [3];
  logic [dsproj_pkg::RowW-1:0]  proj_row_q [3];
  logic [dsproj_pkg::SizeW-1:0] width_q;
  logic [dsproj_pkg::SizeW-1:0] height_q;

  // pipeline control
  logic                 adv;
  logic [NumStages-1:0] v_q;

  // stage payloads
  logic signed [dsproj_pkg::DirW-1:0]   dir [3];
  logic signed [dsproj_pkg::Prod1W-1:0] p1_d [9];
  logic signed [dsproj_pkg::Prod1W-1:0] p1_q [9];
  logic signed [dsproj_pkg::EyeW-1:0]   eye_d [3];
  logic signed [dsproj_pkg::EyeW-1:0]   eye_q [3];
  logic signed [dsproj_pkg::Prod2W-1:0] p3_d [9];
  logic signed [dsproj_pkg::Prod2W-1:0] p3_q [9];
  logic signed [dsproj_pkg::ClipW-1:0]  clip_d [3];
  logic signed [dsproj_pkg::ClipW-1:0]  clip_q [3];
  logic signed [dsproj_pkg::SumW-1:0]   ax_d, ay_d;
  logic signed [dsproj_pkg::SumW-1:0]   ax_q, ay_q;
  logic signed [dsproj_pkg::ClipW-1:0]  cw5_q, cw6_q;
  logic                                 vis5_d, vis5_q, vis6_q;
  logic        [dsproj_pkg::ScaleW-1:0] xlo_d, ylo_d, xlo_q, ylo_q;
  logic signed [dsproj_pkg::ScaleW-1:0] xhi_d, yhi_d, xhi_q, yhi_q;
  logic signed [dsproj_pkg::NumW-1:0]   nx, ny;

  // quotient pipeline, index 0 is the entry stage
  logic [dsproj_pkg::RemW-1:0] dv_rem_x_q [dsproj_pkg::DivSteps+1];
  logic [dsproj_pkg::RemW-1:0] dv_rem_y_q [dsproj_pkg::DivSteps+1];
  logic [dsproj_pkg::OutW-1:0] dv_quo_x_q [dsproj_pkg::DivSteps+1];
  logic [dsproj_pkg::OutW-1:0] dv_quo_y_q [dsproj_pkg::DivSteps+1];
  logic [dsproj_pkg::DenW-1:0] dv_den_q   [dsproj_pkg::DivSteps+1];
  logic                        dv_neg_x_q [dsproj_pkg::DivSteps+1];
  logic                        dv_neg_y_q [dsproj_pkg::DivSteps+1];
  logic                        dv_vis_q   [dsproj_pkg::DivSteps+1];

  // output stage
  logic [dsproj_pkg::OutW-1:0] qx_last, qy_last;
  logic [dsproj_pkg::OutW-1:0] sx_mag, sy_mag;
  logic                        vis_q;
  logic signed [dsproj_pkg::OutW-1:0] sx_d, sy_d, sx_q, sy_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        view_row_q[r] <= dsproj_pkg::UnitRow[r];
        proj_row_q[r] <= dsproj_pkg::UnitRow[r];
      end
      width_q  <= dsproj_pkg::WidthReset;
      height_q <= dsproj_pkg::HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dsproj_pkg::cfg_reg_e'(cfg_index_i))
        dsproj_pkg::RegViewRowX: view_row_q[0] <= cfg_data_i;
        dsproj_pkg::RegViewRowY: view_row_q[1] <= cfg_data_i;
        dsproj_pkg::RegViewRowZ: view_row_q[2] <= cfg_data_i;
        dsproj_pkg::RegProjRowX: proj_row_q[0] <= cfg_data_i;
        dsproj_pkg::RegProjRowY: proj_row_q[1] <= cfg_data_i;
        dsproj_pkg::RegProjRowW: proj_row_q[2] <= cfg_data_i;
        dsproj_pkg::RegScreenW:  width_q  <= cfg_data_i[dsproj_pkg::SizeW-1:0];
        dsproj_pkg::RegScreenH:  height_q <= cfg_data_i[dsproj_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves unless the result is held
  assign adv        = !v_q[LastStage] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i};
    end
  end

  // stage 1: view rotation products
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p1_d[3*r+c] = dsproj_pkg::Prod1W'(dsproj_pkg::coef(view_row_q[r], c))
                    * dsproj_pkg::Prod1W'(dir[c]);
      end
    end
  end

  // stage 2: eye space sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      eye_d[r] = dsproj_pkg::EyeW'(p1_q[3*r]) + dsproj_pkg::EyeW'(p1_q[3*r+1])
               + dsproj_pkg::EyeW'(p1_q[3*r+2]);
    end
  end

  // stage 3: projection products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p3_d[3*r+c] = dsproj_pkg::Prod2W'(dsproj_pkg::coef(proj_row_q[r], c))
                    * dsproj_pkg::Prod2W'(eye_q[c]);
      end
    end
  end

  // stage 4: clip space sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip_d[r] = dsproj_pkg::ClipW'(p3_q[3*r]) + dsproj_pkg::ClipW'(p3_q[3*r+1])
                + dsproj_pkg::ClipW'(p3_q[3*r+2]);
    end
  end

  // stage 5: visibility test and offset numerators
  assign vis5_d = (clip_q[2] >= dsproj_pkg::CwThreshold);
  assign ax_d   = dsproj_pkg::SumW'(clip_q[0]) + dsproj_pkg::SumW'(clip_q[2]);
  assign ay_d   = dsproj_pkg::SumW'(clip_q[2]) - dsproj_pkg::SumW'(clip_q[1]);

  // stage 6: viewport scale, split into two partial products
  assign xlo_d = dsproj_pkg::ScaleW'(ax_q[dsproj_pkg::SplitLo-1:0])
               * dsproj_pkg::ScaleW'(width_q);
  assign ylo_d = dsproj_pkg::ScaleW'(ay_q[dsproj_pkg::SplitLo-1:0])
               * dsproj_pkg::ScaleW'(height_q);
  assign xhi_d = dsproj_pkg::ScaleW'($signed(ax_q[dsproj_pkg::SumW-1:dsproj_pkg::SplitLo]))
               * dsproj_pkg::ScaleW'($signed({1'b0, width_q}));
  assign yhi_d = dsproj_pkg::ScaleW'($signed(ay_q[dsproj_pkg::SumW-1:dsproj_pkg::SplitLo]))
               * dsproj_pkg::ScaleW'($signed({1'b0, height_q}));

  // stage 7: recombine, add cw for rounding, fold the sign for floor division
  assign nx = (dsproj_pkg::NumW'(xhi_q) << dsproj_pkg::SplitLo)
            + dsproj_pkg::NumW'(xlo_q) + dsproj_pkg::NumW'(cw6_q);
  assign ny = (dsproj_pkg::NumW'(yhi_q) << dsproj_pkg::SplitLo)
            + dsproj_pkg::NumW'(ylo_q) + dsproj_pkg::NumW'(cw6_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q   <= p1_d;
      eye_q  <= eye_d;
      p3_q   <= p3_d;
      clip_q <= clip_d;
      vis5_q <= vis5_d;
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      cw5_q  <= clip_q[2];
      vis6_q <= vis5_q;
      cw6_q  <= cw5_q;
      xlo_q  <= xlo_d;
      ylo_q  <= ylo_d;
      xhi_q  <= xhi_d;
      yhi_q  <= yhi_d;
      // negative n: floor(n/d) = ~floor(~n/d)
      dv_rem_x_q[0] <= nx[dsproj_pkg::RemW-1:0] ^ {dsproj_pkg::RemW{nx[dsproj_pkg::NumW-1]}};
      dv_rem_y_q[0] <= ny[dsproj_pkg::RemW-1:0] ^ {dsproj_pkg::RemW{ny[dsproj_pkg::NumW-1]}};
      dv_neg_x_q[0] <= nx[dsproj_pkg::NumW-1];
      dv_neg_y_q[0] <= ny[dsproj_pkg::NumW-1];
      dv_quo_x_q[0] <= '0;
      dv_quo_y_q[0] <= '0;
      dv_den_q[0]   <= {cw6_q[dsproj_pkg::DenW-2:0], 1'b0};
      dv_vis_q[0]   <= vis6_q;
    end
  end

  // restoring quotient pipeline, msb first; a set top bit means overflow
  for (genvar j = 0; j < dsproj_pkg::DivSteps; j++) begin : g_div
    localparam int unsigned Shift = dsproj_pkg::DivSteps - 1 - j;
    logic [dsproj_pkg::DivW-1:0] den_sh;
    logic [dsproj_pkg::DivW-1:0] trial_x, trial_y;
    logic                        ge_x, ge_y;

    always_comb begin
      den_sh  = dsproj_pkg::DivW'(dv_den_q[j]) << Shift;
      trial_x = dsproj_pkg::DivW'(dv_rem_x_q[j]) - den_sh;
      trial_y = dsproj_pkg::DivW'(dv_rem_y_q[j]) - den_sh;
      ge_x    = !trial_x[dsproj_pkg::DivW-1];
      ge_y    = !trial_y[dsproj_pkg::DivW-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_x_q[j+1] <= ge_x ? trial_x[dsproj_pkg::RemW-1:0] : dv_rem_x_q[j];
        dv_rem_y_q[j+1] <= ge_y ? trial_y[dsproj_pkg::RemW-1:0] : dv_rem_y_q[j];
        dv_quo_x_q[j+1] <= {dv_quo_x_q[j][dsproj_pkg::OutW-2:0], ge_x};
        dv_quo_y_q[j+1] <= {dv_quo_y_q[j][dsproj_pkg::OutW-2:0], ge_y};
        dv_den_q[j+1]   <= dv_den_q[j];
        dv_neg_x_q[j+1] <= dv_neg_x_q[j];
        dv_neg_y_q[j+1] <= dv_neg_y_q[j];
        dv_vis_q[j+1]   <= dv_vis_q[j];
      end
    end
  end

  // output stage: saturate, restore sign, blank when not visible
  assign qx_last = dv_quo_x_q[dsproj_pkg::DivSteps];
  assign qy_last = dv_quo_y_q[dsproj_pkg::DivSteps];
  assign sx_mag  = qx_last[dsproj_pkg::OutW-1] ? {1'b0, {(dsproj_pkg::OutW-1){1'b1}}}
                                               : {1'b0, qx_last[dsproj_pkg::OutW-2:0]};
  assign sy_mag  = qy_last[dsproj_pkg::OutW-1] ? {1'b0, {(dsproj_pkg::OutW-1){1'b1}}}
                                               : {1'b0, qy_last[dsproj_pkg::OutW-2:0]};
  assign sx_d = dv_vis_q[dsproj_pkg::DivSteps]
              ? $signed(sx_mag ^ {dsproj_pkg::OutW{dv_neg_x_q[dsproj_pkg::DivSteps]}}) : '0;
  assign sy_d = dv_vis_q[dsproj_pkg::DivSteps]
              ? $signed(sy_mag ^ {dsproj_pkg::OutW{dv_neg_y_q[dsproj_pkg::DivSteps]}}) : '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= dv_vis_q[dsproj_pkg::DivSteps];
      sx_q  <= sx_d;
      sy_q  <= sy_d;
    end
  end

  assign out_valid_o = v_q[LastStage];
  assign visible_o   = vis_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

  // checks
  a_blank_when_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("hidden result carries a nonzero position");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request missing from the first stage");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(v_q))
    else $error("pipeline moved while the result was held");

  a_no_output_from_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !v_q[LastStage-1] |=> !out_valid_o)
    else $error("result appeared without a request behind it");

endmodule

`default_nettype wire
